// File: hdl/psu_pkg.sv
package psu_pkg;

    localparam int DEF_MAX_ROW_BYTES = 8192;
    localparam int DEF_MAX_BPP       = 8;

    localparam int BPP_W  = 4;
    localparam int LEN_W  = 14;
    localparam int ROWS_W = 16;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_BPP      = 2'd0;
    localparam logic [CFG_AW-1:0] REG_ROW_LEN  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_IMG_ROWS = 2'd2;

    localparam logic [BPP_W-1:0]  RST_BPP      = 4'd3;
    localparam logic [LEN_W-1:0]  RST_ROW_LEN  = 14'd4096;
    localparam logic [ROWS_W-1:0] RST_IMG_ROWS = 16'd1;

    typedef logic [2:0] filt_t;

    localparam filt_t FILT_NONE  = 3'd0;
    localparam filt_t FILT_SUB   = 3'd1;
    localparam filt_t FILT_UP    = 3'd2;
    localparam filt_t FILT_AVG   = 3'd3;
    localparam filt_t FILT_PAETH = 3'd4;

endpackage

// File: hdl/psu_predict.sv
module psu_predict (
    input  psu_pkg::filt_t filter_type,
    input  logic [7:0]     left_byte,
    input  logic [7:0]     above_byte,
    input  logic [7:0]     corner_byte,
    output logic [7:0]     pred
);

    logic [8:0]        sum;
    logic signed [9:0] d_bc;
    logic signed [9:0] d_ac;
    logic signed [9:0] d_p;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [7:0]        paeth;

    always_comb begin
        sum  = {1'b0, left_byte} + {1'b0, above_byte};
        d_bc = $signed({2'b00, above_byte}) - $signed({2'b00, corner_byte});
        d_ac = $signed({2'b00, left_byte}) - $signed({2'b00, corner_byte});
        d_p  = d_bc + d_ac;
        pa   = (d_bc < 0) ? 10'(-d_bc) : 10'(d_bc);
        pb   = (d_ac < 0) ? 10'(-d_ac) : 10'(d_ac);
        pc   = (d_p  < 0) ? 10'(-d_p)  : 10'(d_p);
        if (pa <= pb && pa <= pc) begin
            paeth = left_byte;
        end else if (pb <= pc) begin
            paeth = above_byte;
        end else begin
            paeth = corner_byte;
        end

        case (filter_type)
            psu_pkg::FILT_SUB:   pred = left_byte;
            psu_pkg::FILT_UP:    pred = above_byte;
            psu_pkg::FILT_AVG:   pred = sum[8:1];
            psu_pkg::FILT_PAETH: pred = paeth;
            default:             pred = 8'd0;
        endcase
    end

endmodule

// File: hdl/png_scanline_unfilter.sv
// Pipeline: two register stages, the reconstruct stage and then the output register.
// Throughput: one byte per cycle while m_ready keeps the output moving, set by the line
// store read and the one-stage left-neighbor feedback; filter-type bytes give no result.
// Reset (aresetn low, synchronous): counters and valids clear, registers load
// their defaults. The line store is not cleared; the first row of an image reads zero above.
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES = psu_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_BPP       = psu_pkg::DEF_MAX_BPP
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [psu_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [psu_pkg::CFG_DW-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_filtered_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_pixel_byte,
    output logic                      m_row_end,
    output logic                      m_image_end,
    output logic                      m_bad_filter
);

    localparam int COL_W  = $clog2(MAX_ROW_BYTES);
    localparam int CMP_W  = (COL_W + 1 > psu_pkg::LEN_W) ? COL_W + 1 : psu_pkg::LEN_W;
    localparam int BIX_W  = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
    localparam int BPP_W  = psu_pkg::BPP_W;
    localparam int ROWS_W = psu_pkg::ROWS_W;

    logic [BPP_W-1:0]          bpp_reg;
    logic [psu_pkg::LEN_W-1:0] row_len_reg;
    logic [ROWS_W-1:0]         img_rows_reg;

    logic [BPP_W-1:0]  bpp_eff;
    logic [CMP_W-1:0]  len_eff;
    logic [ROWS_W-1:0] rows_eff;

    logic                awaiting_reg;
    psu_pkg::filt_t      ftype_reg;
    logic                fbad_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROWS_W-1:0]   row_reg;

    logic                in_acc;
    logic                data_acc;
    logic [CMP_W-1:0]    col_inc;
    logic [ROWS_W:0]     row_inc;
    logic                row_end_c;
    logic                img_end_c;

    logic                s1_valid_reg;
    logic [7:0]          s1_x_reg;
    logic [COL_W-1:0]    s1_col_reg;
    psu_pkg::filt_t      s1_ftype_reg;
    logic                s1_bad_reg;
    logic                s1_rend_reg;
    logic                s1_iend_reg;
    logic                s1_first_reg;
    logic                s1_move;

    logic [7:0]          above_mem [MAX_ROW_BYTES];
    logic [7:0]          above_rdata_reg;
    logic [7:0]          left_cur_reg [MAX_BPP];
    logic [7:0]          left_abv_reg [MAX_BPP];

    logic [BIX_W-1:0]    left_idx;
    logic                has_left;
    logic [7:0]          a_byte;
    logic [7:0]          b_byte;
    logic [7:0]          c_byte;
    logic [7:0]          pred;
    logic [7:0]          v_byte;

    logic                m_valid_reg;
    logic [7:0]          m_pixel_reg;
    logic                m_rend_reg;
    logic                m_iend_reg;
    logic                m_bad_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg      <= psu_pkg::RST_BPP;
            row_len_reg  <= psu_pkg::RST_ROW_LEN;
            img_rows_reg <= psu_pkg::RST_IMG_ROWS;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                psu_pkg::REG_BPP:      bpp_reg      <= cfg_wdata[BPP_W-1:0];
                psu_pkg::REG_ROW_LEN:  row_len_reg  <= cfg_wdata[psu_pkg::LEN_W-1:0];
                psu_pkg::REG_IMG_ROWS: img_rows_reg <= cfg_wdata[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (bpp_reg == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (bpp_reg > BPP_W'(MAX_BPP)) begin
            bpp_eff = BPP_W'(MAX_BPP);
        end else begin
            bpp_eff = bpp_reg;
        end

        if (row_len_reg == '0) begin
            len_eff = CMP_W'(1);
        end else if (CMP_W'(row_len_reg) > CMP_W'(MAX_ROW_BYTES)) begin
            len_eff = CMP_W'(MAX_ROW_BYTES);
        end else begin
            len_eff = CMP_W'(row_len_reg);
        end

        rows_eff = (img_rows_reg == '0) ? ROWS_W'(1) : img_rows_reg;
    end

    // request side: row and column tracking
    assign s1_move  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_move;
    assign in_acc   = s_valid && s_ready;
    assign data_acc = in_acc && !awaiting_reg;

    assign col_inc   = CMP_W'(col_reg) + CMP_W'(1);
    assign row_inc   = {1'b0, row_reg} + {{ROWS_W{1'b0}}, 1'b1};
    assign row_end_c = (col_inc >= len_eff);
    assign img_end_c = row_end_c && (row_inc >= {1'b0, rows_eff});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg <= 1'b1;
            ftype_reg    <= psu_pkg::FILT_NONE;
            fbad_reg     <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
        end else if (in_acc) begin
            if (awaiting_reg) begin
                awaiting_reg <= 1'b0;
                col_reg      <= '0;
                if (s_filtered_byte > 8'(psu_pkg::FILT_PAETH)) begin
                    ftype_reg <= psu_pkg::FILT_NONE;
                    fbad_reg  <= 1'b1;
                end else begin
                    ftype_reg <= s_filtered_byte[2:0];
                    fbad_reg  <= 1'b0;
                end
            end else if (row_end_c) begin
                awaiting_reg <= 1'b1;
                col_reg      <= '0;
                row_reg      <= img_end_c ? '0 : row_inc[ROWS_W-1:0];
            end else begin
                col_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    // reconstruct stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (data_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_acc) begin
            s1_x_reg     <= s_filtered_byte;
            s1_col_reg   <= col_reg;
            s1_ftype_reg <= ftype_reg;
            s1_bad_reg   <= fbad_reg;
            s1_rend_reg  <= row_end_c;
            s1_iend_reg  <= img_end_c;
            s1_first_reg <= (row_reg == '0);
        end
    end

    // line store: read at request, write back when the byte leaves the stage
    always_ff @(posedge aclk) begin
        if (data_acc) begin
            above_rdata_reg <= above_mem[col_reg];
        end
        if (s1_move) begin
            above_mem[s1_col_reg] <= v_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            for (int i = MAX_BPP - 1; i > 0; i--) begin
                left_cur_reg[i] <= left_cur_reg[i-1];
                left_abv_reg[i] <= left_abv_reg[i-1];
            end
            left_cur_reg[0] <= v_byte;
            left_abv_reg[0] <= b_byte;
        end
    end

    // left neighbors before the row start read as zero
    assign left_idx = BIX_W'(bpp_eff - BPP_W'(1));
    assign has_left = (CMP_W'(s1_col_reg) >= CMP_W'(bpp_eff));
    assign a_byte   = has_left ? left_cur_reg[left_idx] : 8'd0;
    assign c_byte   = has_left ? left_abv_reg[left_idx] : 8'd0;
    assign b_byte   = s1_first_reg ? 8'd0 : above_rdata_reg;

    psu_predict u_predict (
        .filter_type (s1_ftype_reg),
        .left_byte   (a_byte),
        .above_byte  (b_byte),
        .corner_byte (c_byte),
        .pred        (pred)
    );

    assign v_byte = s1_x_reg + pred;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_pixel_reg <= v_byte;
            m_rend_reg  <= s1_rend_reg;
            m_iend_reg  <= s1_iend_reg;
            m_bad_reg   <= s1_bad_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_byte = m_pixel_reg;
    assign m_row_end    = m_rend_reg;
    assign m_image_end  = m_iend_reg;
    assign m_bad_filter = m_bad_reg;

endmodule
